/* sv/mhpq_pkg.sv */
package mhpq_pkg;

    // Number of key slots in the cell row.
    localparam int DEPTH = 128;
    localparam int KEY_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 8;
    localparam int ENTRY_W = 8;
    localparam int STATUS_W = 2;

    // Result payload layout, lowest bit first.
    localparam int OUT_BITS = STATUS_W + KEY_W + ENTRY_W + KEY_W;
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;

    // Operation broadcast to every cell for one cycle.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage

/* sv/mhpq_cell.sv */
module mhpq_cell (
    input  logic              aclk,
    input  mhpq_pkg::cell_ctl_t ctl,
    input  mhpq_pkg::key_t    key,
    input  logic              occ,
    input  mhpq_pkg::key_t    prev_val,
    input  logic              prev_occ,
    input  mhpq_pkg::key_t    next_val,
    output mhpq_pkg::key_t    val
);
    import mhpq_pkg::*;

    key_t val_reg;
    key_t val_next;
    logic keep;
    logic prev_ge;

    // Row is sorted largest first; an insert shifts the smaller tail right.
    assign keep    = occ && (val_reg >= key);
    assign prev_ge = prev_occ && (prev_val >= key);

    always_comb begin
        val_next = val_reg;
        if (ctl.ins) begin
            if (keep) begin
                val_next = val_reg;
            end else if (prev_ge) begin
                val_next = key;
            end else begin
                val_next = prev_val;
            end
        end else if (ctl.del) begin
            val_next = next_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

/* sv/max_heap_priority_queue.sv */
// Result path: an accepted request's result is held in the pending-result registers, then
//   moves into the output register on m_tdata. No new request is taken while a result is
//   pending: s_tready stays low until the result has moved into the output register.
// A request is applied to the whole cell row in the cycle it is accepted.
// Reset (aresetn low, synchronous): heap empties, capacity_limit returns to 128,
//   no result is pending. Key cells are not cleared.
module max_heap_priority_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    // capacity_limit register
    input  logic                       cfg_wr_en,
    input  logic [mhpq_pkg::CAP_W-1:0] cfg_wr_data,
    // request channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mhpq_pkg::KEY_W-1:0] s_tdata,   // [31:0] key_value
    input  logic                       s_tuser,   // [0] req_type
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mhpq_pkg::OUT_W-1:0] m_tdata    // [1:0] status, [33:2] removed_key,
                                                  // [41:34] entry_count, [73:42] top_key,
                                                  // [79:74] zero
);
    import mhpq_pkg::*;

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAP_W-1:0]    cap_reg;
    logic                pend_reg;
    logic [STATUS_W-1:0] pend_status_reg, status_next;
    key_t                pend_removed_reg, removed_next;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic             accept;
    logic             is_full;
    logic             do_ins;
    logic             do_del;
    logic             xfer;
    logic [CMP_W-1:0] limit;
    key_t             top_key;
    key_t             key_in;
    cell_ctl_t        ctl;

    key_t cell_val [DEPTH];
    logic cell_occ [DEPTH];

    // Hold off new requests while a result waits to move to the output register.
    assign s_tready = !pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign key_in   = key_t'(s_tdata);

    // Effective capacity saturates at the row length.
    assign limit   = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign is_full = CMP_W'(count_reg) >= limit;

    assign do_ins  = accept && (s_tuser == REQ_INSERT) && !is_full;
    assign do_del  = accept && (s_tuser == REQ_DELETE) && (count_reg != '0);
    assign ctl.ins = do_ins;
    assign ctl.del = do_del;

    always_comb begin
        count_next   = count_reg;
        status_next  = ST_OK;
        removed_next = '0;
        if (s_tuser == REQ_INSERT) begin
            if (is_full) begin
                status_next = ST_FULL;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (count_reg == '0) begin
                status_next = ST_EMPTY;
            end else begin
                count_next   = count_reg - CNT_W'(1);
                removed_next = cell_val[0];
            end
        end
    end

    // Row of cells, largest key in cell 0. Cell 0 sees a left neighbor that
    // always wins the compare, so an insert that beats every key lands there.
    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            key_t prev_v;
            logic prev_o;
            key_t next_v;

            assign cell_occ[i] = CNT_W'(i) < count_reg;

            if (i == 0) begin : g_first
                assign prev_v = {1'b0, {(KEY_W-1){1'b1}}};
                assign prev_o = 1'b1;
            end else begin : g_mid
                assign prev_v = cell_val[i-1];
                assign prev_o = cell_occ[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign next_v = cell_val[i];
            end else begin : g_inner
                assign next_v = cell_val[i+1];
            end

            mhpq_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .key      (key_in),
                .occ      (cell_occ[i]),
                .prev_val (prev_v),
                .prev_occ (prev_o),
                .next_val (next_v),
                .val      (cell_val[i])
            );
        end
    endgenerate

    // Advance the pending result once the output register is free or drained.
    assign xfer    = pend_reg && (!m_tvalid_reg || m_tready);
    assign top_key = (count_reg == '0) ? key_t'(0) : cell_val[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (accept) begin
                count_reg <= count_next;
                pend_reg  <= 1'b1;
            end else if (xfer) begin
                pend_reg <= 1'b0;
            end
            if (xfer) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_status_reg  <= status_next;
            pend_removed_reg <= removed_next;
        end
        if (xfer) begin
            m_tdata_reg <= OUT_W'({top_key, ENTRY_W'(count_reg), pend_removed_reg,
                                   pend_status_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/mhpq_checker.sv */
module mhpq_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mhpq_pkg::OUT_W-1:0] m_tdata
);
    import mhpq_pkg::*;

    localparam int RM_LO  = STATUS_W;
    localparam int CNT_LO = STATUS_W + KEY_W;
    localparam int TOP_LO = CNT_LO + ENTRY_W;

    logic [STATUS_W-1:0] st;
    logic [KEY_W-1:0]    removed;
    logic [ENTRY_W-1:0]  cnt;
    logic [KEY_W-1:0]    top;

    assign st      = m_tdata[STATUS_W-1:0];
    assign removed = m_tdata[RM_LO +: KEY_W];
    assign cnt     = m_tdata[CNT_LO +: ENTRY_W];
    assign top     = m_tdata[TOP_LO +: KEY_W];

    // Stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (st == ST_OK) || (st == ST_FULL) || (st == ST_EMPTY))
        else $error("bad status code");

    a_empty_del: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_EMPTY) |-> (removed == '0) && (cnt == '0))
        else $error("empty delete reported keys");

    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (cnt == '0) |-> (top == '0))
        else $error("top key nonzero on empty heap");

    a_full_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_FULL) |-> (cnt != '0) || (top == '0))
        else $error("full reject inconsistent with count");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/max_heap_priority_queue_test.sv */
module max_heap_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mhpq_pkg::*;

    // Run shape: a directed table first, then random phases of equal length.
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 238;
    // One long receiver hold-off, long enough to back the block up into s_tready.
    localparam int HOLD_CYCLES   = 300;
    // A result passes the pending stage and the output register; spare cycles follow before idle.
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400_000;

    // Result payload slices, lowest field first.
    localparam int REMOVED_LSB = STATUS_W;
    localparam int COUNT_LSB   = STATUS_W + KEY_W;
    localparam int TOP_LSB     = STATUS_W + KEY_W + ENTRY_W;

    localparam key_t KEY_MIN  = key_t'(32'h8000_0000);
    localparam key_t KEY_MAX  = key_t'(32'h7FFF_FFFF);
    // Delete requests in the directed table carry this key to show the field is ignored.
    localparam key_t KEY_JUNK = key_t'(32'h5A5A_A5A5);

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        key_t                removed;
        logic [ENTRY_W-1:0]  count;
        key_t                top;
    } heap_result_t;

    // One row of the directed table. When typed is set, want is the expected
    // result as written; otherwise the shadow heap supplies it.
    typedef struct packed {
        logic             set_cap;
        logic [CAP_W-1:0] cap;
        logic             req;
        key_t             key;
        logic             typed;
        heap_result_t     want;
    } directed_step_t;

    localparam heap_result_t NOT_TYPED = '0;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CAP_W-1:0]  cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [KEY_W-1:0]  s_tdata;     // [31:0] key_value
    logic              s_tuser;     // [0] req_type
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;     // [1:0] status, [33:2] removed_key,
                                    // [41:34] entry_count, [73:42] top_key

    // Shadow copy of the heap, its count and the capacity register.
    key_t             shadow_keys [DEPTH];
    int               shadow_count;
    logic [CAP_W-1:0] shadow_cap;

    // Results owed by the block, oldest first.
    heap_result_t owed_results [$];

    idle_mode_t idle_mode;
    logic       want_hold;
    int         cycle_count = 0;
    int         mismatches;
    int         checked;
    int         n_requests;
    int         n_inserted;
    int         n_rejected_full;
    int         n_empty_deletes;
    int         peak_count;

    max_heap_priority_queue u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Capacity as the block applies it: anything above the array depth saturates.
    function automatic int shadow_limit();
        return (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    endfunction

    // Apply one request to the shadow heap and return the result it owes.
    task automatic shadow_apply(input logic req, input key_t key, output heap_result_t res);
        int   pos;
        int   up;
        int   lt;
        int   rt;
        int   best;
        key_t tmp;
        res = '0;
        res.status = ST_OK;
        if (req == REQ_INSERT) begin
            if (shadow_count >= shadow_limit()) begin
                // Full (or capacity lowered under the count): leave the heap alone.
                res.status = ST_FULL;
                n_rejected_full++;
            end else begin
                pos = shadow_count;
                shadow_keys[pos] = key;
                shadow_count++;
                // Sift up past every parent that is strictly smaller.
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (shadow_keys[pos] <= shadow_keys[up])
                        break;
                    tmp = shadow_keys[pos];
                    shadow_keys[pos] = shadow_keys[up];
                    shadow_keys[up] = tmp;
                    pos = up;
                end
                n_inserted++;
                if (shadow_count > peak_count)
                    peak_count = shadow_count;
            end
        end else if (shadow_count == 0) begin
            res.status = ST_EMPTY;
            n_empty_deletes++;
        end else begin
            res.removed = shadow_keys[0];
            shadow_count--;
            if (shadow_count > 0) begin
                // Move the last entry to the root and sift it down; the left
                // child wins a tie because the right must be strictly greater.
                shadow_keys[0] = shadow_keys[shadow_count];
                pos = 0;
                while (1) begin
                    lt = 2 * pos + 1;
                    rt = lt + 1;
                    best = pos;
                    if (lt < shadow_count && shadow_keys[lt] > shadow_keys[best])
                        best = lt;
                    if (rt < shadow_count && shadow_keys[rt] > shadow_keys[best])
                        best = rt;
                    if (best == pos)
                        break;
                    tmp = shadow_keys[pos];
                    shadow_keys[pos] = shadow_keys[best];
                    shadow_keys[best] = tmp;
                    pos = best;
                end
            end
        end
        res.count = ENTRY_W'(shadow_count);
        res.top = (shadow_count > 0) ? shadow_keys[0] : key_t'(0);
    endtask

    // Offer one request transaction, starting and ending at a falling edge.
    task automatic send_request(input logic req, input key_t key, input logic typed,
                                input heap_result_t want);
        heap_result_t predicted;
        // Insert sender gaps for the current idle mode.
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < 77) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 29)) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = key;
        do @(posedge aclk); while (!s_tready);
        // Accepted at this edge: advance the shadow heap now.
        shadow_apply(req, key, predicted);
        owed_results.push_back(typed ? want : predicted);
        n_requests++;
        @(negedge aclk);
    endtask

    // Drop valid and hold off until the block has returned everything owed.
    task automatic settle();
        s_tvalid = 1'b0;
        while (owed_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write capacity_limit only once the block is idle.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        settle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = cap;
        shadow_cap  = cap;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // Result sink: random stalls per idle mode, plus one long hold-off that
    // it counts on its own while the sender keeps offering requests.
    initial begin : result_sink
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (want_hold && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (idle_mode == IDLE_RECV) begin
                m_tready = ($urandom_range(99) >= 77);
            end else if (idle_mode == IDLE_BOTH) begin
                m_tready = ($urandom_range(99) >= 29);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Compare every result transaction with the oldest owed result.
    always @(posedge aclk) begin : result_check
        heap_result_t got;
        heap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status  = m_tdata[STATUS_W-1:0];
            got.removed = m_tdata[REMOVED_LSB +: KEY_W];
            got.count   = m_tdata[COUNT_LSB +: ENTRY_W];
            got.top     = m_tdata[TOP_LSB +: KEY_W];
            if (owed_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with nothing owed: status %0d count %0d top %0d",
                         $time, got.status, got.count, got.top);
            end else begin
                want = owed_results.pop_front();
                checked++;
                if (got.status !== want.status) begin
                    mismatches++;
                    $display("%0t ns: status expected %0d actual %0d",
                             $time, want.status, got.status);
                end
                if (got.removed !== want.removed) begin
                    mismatches++;
                    $display("%0t ns: removed_key expected %0d actual %0d",
                             $time, want.removed, got.removed);
                end
                if (got.count !== want.count) begin
                    mismatches++;
                    $display("%0t ns: entry_count expected %0d actual %0d",
                             $time, want.count, got.count);
                end
                if (got.top !== want.top) begin
                    mismatches++;
                    $display("%0t ns: top_key expected %0d actual %0d",
                             $time, want.top, got.top);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: run exceeded %0d cycles, %0d results still owed",
                     $time, CYCLE_LIMIT, owed_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        directed_step_t   steps [DIRECTED_ROWS];
        logic [CAP_W-1:0] phase_caps [PHASE_COUNT];
        logic             filling;
        int               over_full;
        int               under_empty;
        logic             req;
        key_t             key;

        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = REQ_INSERT;
        idle_mode       = IDLE_NONE;
        want_hold       = 1'b0;
        shadow_count    = 0;
        shadow_cap      = CAP_RESET;
        mismatches      = 0;
        checked         = 0;
        n_requests      = 0;
        n_inserted      = 0;
        n_rejected_full = 0;
        n_empty_deletes = 0;
        peak_count      = 0;

        // set_cap, cap, req, key, typed, {status, removed, count, top}
        steps = '{
            // delete on the empty heap straight after reset
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 32'sd0}},
            // key extremes
            '{1'b0, 8'd0,   REQ_INSERT, KEY_MIN,      1'b1, '{ST_OK, 32'sd0, 8'd1, KEY_MIN}},
            '{1'b0, 8'd0,   REQ_INSERT, KEY_MAX,      1'b1, '{ST_OK, 32'sd0, 8'd2, KEY_MAX}},
            '{1'b0, 8'd0,   REQ_INSERT, 32'sd0,       1'b0, NOT_TYPED},
            '{1'b0, 8'd0,   REQ_INSERT, -32'sd1,      1'b0, NOT_TYPED},
            // equal keys exercise the sift ties
            '{1'b0, 8'd0,   REQ_INSERT, 32'sd5,       1'b0, NOT_TYPED},
            '{1'b0, 8'd0,   REQ_INSERT, 32'sd5,       1'b0, NOT_TYPED},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b1, '{ST_OK, KEY_MAX, 8'd5, 32'sd5}},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b0, NOT_TYPED},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b0, NOT_TYPED},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b0, NOT_TYPED},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b0, NOT_TYPED},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b1, '{ST_OK, KEY_MIN, 8'd0, 32'sd0}},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 32'sd0}},
            // capacity zero rejects every insert
            '{1'b1, 8'd0,   REQ_INSERT, 32'sd1234,    1'b1, '{ST_FULL, 32'sd0, 8'd0, 32'sd0}},
            // capacity one: second insert bounces
            '{1'b1, 8'd1,   REQ_INSERT, 32'sd10,      1'b1, '{ST_OK, 32'sd0, 8'd1, 32'sd10}},
            '{1'b0, 8'd0,   REQ_INSERT, 32'sd20,      1'b1, '{ST_FULL, 32'sd0, 8'd1, 32'sd10}},
            // capacity above the depth saturates
            '{1'b1, 8'd255, REQ_INSERT, 32'sd20,      1'b0, NOT_TYPED},
            '{1'b0, 8'd0,   REQ_INSERT, 32'sd30,      1'b0, NOT_TYPED},
            // capacity lowered under the count: inserts bounce, deletes still work
            '{1'b1, 8'd2,   REQ_INSERT, 32'sd40,      1'b1, '{ST_FULL, 32'sd0, 8'd3, 32'sd30}},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b1, '{ST_OK, 32'sd30, 8'd2, 32'sd20}},
            '{1'b0, 8'd0,   REQ_INSERT, 32'sd50,      1'b1, '{ST_FULL, 32'sd0, 8'd2, 32'sd20}},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b0, NOT_TYPED},
            '{1'b0, 8'd0,   REQ_DELETE, KEY_JUNK,     1'b0, NOT_TYPED},
            '{1'b1, 8'd128, REQ_DELETE, KEY_JUNK,     1'b1, '{ST_EMPTY, 32'sd0, 8'd0, 32'sd0}}
        };

        // Capacity per random phase; the heap carries over, so a drop in
        // capacity often lands below the current count.
        phase_caps = '{CAP_RESET, 8'd7, 8'd255, 8'd1, 8'd0, CAP_RESET,
                       CAP_W'($urandom_range(2, 127)), CAP_RESET};

        // Hold reset low, then release it at a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (steps[i]) begin
            if (steps[i].set_cap)
                write_capacity(steps[i].cap);
            send_request(steps[i].req, steps[i].key, steps[i].typed, steps[i].want);
        end

        // Random part: alternate fill and drain runs so the heap keeps
        // reaching its limit and emptying out, with a tenth of the requests
        // going against the current direction.
        filling     = 1'b1;
        over_full   = 0;
        under_empty = 0;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_capacity(phase_caps[ph]);
            idle_mode = idle_mode_t'(ph % 4);
            // Phase four runs with no idling, so the long hold-off backs the block up.
            if (ph == 4)
                want_hold = 1'b1;
            repeat (PHASE_ITEMS) begin
                if (filling && shadow_count >= shadow_limit())
                    over_full++;
                if (!filling && shadow_count == 0)
                    under_empty++;
                if (over_full >= 3) begin
                    filling   = 1'b0;
                    over_full = 0;
                end
                if (under_empty >= 2) begin
                    filling     = 1'b1;
                    under_empty = 0;
                end
                if ($urandom_range(99) < 90)
                    req = filling ? REQ_INSERT : REQ_DELETE;
                else
                    req = filling ? REQ_DELETE : REQ_INSERT;
                // Mix full-range keys with a narrow band that produces many ties.
                case ($urandom_range(9))
                    0, 1, 2, 3: key = key_t'($urandom);
                    4, 5, 6:    key = key_t'($urandom_range(16)) - 32'sd8;
                    7:          key = KEY_MIN;
                    8:          key = KEY_MAX;
                    default:    key = $urandom_range(1) ? key_t'(0) : key_t'(-1);
                endcase
                send_request(req, key, 1'b0, NOT_TYPED);
            end
        end

        settle();
        $display("Ran %0d requests, %0d capacity settings: %0d kept, %0d full, %0d empty",
                 n_requests, PHASE_COUNT + 5, n_inserted, n_rejected_full, n_empty_deletes);
        $display("Heap peaked at %0d keys; %0d results compared, %0d field mismatches",
                 peak_count, checked, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
